/* rtl/lsnm_pkg.sv */
// ----------------------------------------------------------------------------
// lsnm_pkg
// Shared types and constants for the node stack with per-node marks.
// ----------------------------------------------------------------------------
package lsnm_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int NODE_W           = 10;
  localparam int NODE_SPAN        = 1 << NODE_W;
  localparam int CFG_W            = 11;
  localparam int CMD_W            = 2;
  localparam int STATUS_W         = 2;
  localparam int MARK_W           = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_WHITE = 2'd0,
    MARK_GRAY  = 2'd1,
    MARK_BLACK = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic eval;
    logic sweep;
  } lsnm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic out_free;
    logic sweep_last;
  } lsnm_sts_t;

endpackage

/* rtl/lsnm_ctrl.sv */
// ----------------------------------------------------------------------------
// lsnm_ctrl
// Sequencer: accept, memory read, evaluate/commit, and mark sweep.
// ----------------------------------------------------------------------------
module lsnm_ctrl
  import lsnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsnm_sts_t sts,
  output lsnm_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.latch_in = 1'b0;
    cmd.eval     = 1'b0;
    cmd.sweep    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.out_free) begin
          cmd.eval   = 1'b1;
          state_next = sts.is_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lsnm_datapath.sv */
// ----------------------------------------------------------------------------
// lsnm_datapath
// Stack memory, mark memory, entry counter, capacity register, result register.
// ----------------------------------------------------------------------------
module lsnm_datapath
  import lsnm_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  lsnm_cmd_t           cmd,
  output lsnm_sts_t           sts,
  input  logic                cfg_valid,
  input  logic [CFG_W-1:0]    capacity_in_use,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [NODE_W-1:0]   popped_node,
  output logic [MARK_W-1:0]   node_mark,
  output logic                is_full,
  output logic                is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SA = $clog2(CAPACITY);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;
  localparam int MD = (CAPACITY < NODE_SPAN) ? CAPACITY : NODE_SPAN;
  localparam int MA = $clog2(MD);

  logic [NODE_W-1:0] stack_mem [CAPACITY];
  logic [MARK_W-1:0] mark_mem  [MD];

  logic [CFG_W-1:0]  cfg;
  logic [CMD_W-1:0]  cmd_q;
  logic [NODE_W-1:0] node_q;
  logic [CW-1:0]     count, count_next;
  logic [MA-1:0]     sweep_addr;
  logic [NODE_W-1:0] stack_rd;
  logic [MARK_W-1:0] mark_rd;

  logic [XW-1:0]     cfg_x;
  logic [CW-1:0]     cap_eff;
  logic              full_now, in_cap, push_ok, pop_ok;
  logic [CW-1:0]     count_m1;

  logic              mark_we;
  logic [MA-1:0]     mark_wa;
  logic [MARK_W-1:0] mark_wd;

  logic [STATUS_W-1:0] res_status;
  logic [NODE_W-1:0]   res_popped;
  logic [MARK_W-1:0]   res_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      cfg <= capacity_in_use;
    end
  end

  // effective capacity: register clamped to 1..CAPACITY
  always_comb begin
    cfg_x = XW'(cfg);
    if (cfg_x == '0) begin
      cap_eff = CW'(1);
    end else if (cfg_x >= XW'(CAPACITY)) begin
      cap_eff = CW'(CAPACITY);
    end else begin
      cap_eff = CW'(cfg_x);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_q  <= command;
      node_q <= node;
    end
  end

  assign count_m1 = count - CW'(1);
  assign full_now = (count >= cap_eff);
  assign in_cap   = (XW'(node_q) < XW'(cap_eff));
  assign push_ok  = (cmd_q == CMD_PUSH) && !full_now && in_cap;
  assign pop_ok   = (cmd_q == CMD_POP) && (count != '0);

  always_comb begin
    count_next = count;
    res_status = STS_DONE;
    res_popped = '0;
    res_mark   = MARK_WHITE;
    case (cmd_q)
      CMD_PUSH: begin
        if (full_now) begin
          res_status = STS_FULL;
          res_mark   = in_cap ? mark_rd : MARK_WHITE;
        end else if (!in_cap) begin
          res_status = STS_RANGE;
        end else begin
          count_next = count + CW'(1);
          res_mark   = MARK_GRAY;
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          res_status = STS_EMPTY;
        end else begin
          count_next = count_m1;
          res_popped = stack_rd;
          res_mark   = MARK_BLACK;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.eval) begin
      count <= count_next;
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (cmd.eval && push_ok) begin
      stack_mem[count[SA-1:0]] <= node_q;
    end
    stack_rd <= stack_mem[count_m1[SA-1:0]];
  end

  // mark memory: sweep, gray on push, black on pop
  always_comb begin
    mark_we = 1'b0;
    mark_wa = sweep_addr;
    mark_wd = MARK_WHITE;
    if (cmd.sweep) begin
      mark_we = 1'b1;
    end else if (cmd.eval && push_ok) begin
      mark_we = 1'b1;
      mark_wa = node_q[MA-1:0];
      mark_wd = MARK_GRAY;
    end else if (cmd.eval && pop_ok) begin
      mark_we = 1'b1;
      mark_wa = stack_rd[MA-1:0];
      mark_wd = MARK_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd <= mark_mem[node_q[MA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sts.sweep_last ? '0 : sweep_addr + MA'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.eval) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status      <= res_status;
      popped_node <= res_popped;
      node_mark   <= res_mark;
      is_full     <= (count_next >= cap_eff);
      is_empty    <= (count_next == '0);
    end
  end

  assign sts.is_clear   = (cmd_q == CMD_CLEAR);
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.sweep_last = (sweep_addr == MA'(MD - 1));

endmodule

/* rtl/lifo_stack_with_node_marks_top.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_node_marks_top
// Bounded stack of node numbers with a white/gray/black mark per node.
// ----------------------------------------------------------------------------
// Push, pop and no-op commands occupy the block from acceptance to commit: the
// accept state registers the command, the read state does the synchronous reads
// of the stack and mark memories, and the commit state commits and loads the
// result register. in_ready is high again in the same cycle as the result
// appears. A result that is not taken holds the block in the commit step. One
// transaction is in flight at a time. Clear additionally sweeps the mark memory
// one entry per cycle (min(CAPACITY, 1024) entries, 1024 by default) after
// its result is issued; the same sweep runs after reset, with in_ready low
// throughout.
// The capacity register may be written at any time the block is idle.
module lifo_stack_with_node_marks_top
  import lsnm_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    capacity_in_use,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [NODE_W-1:0]   node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [NODE_W-1:0]   popped_node,
  output logic [MARK_W-1:0]   node_mark,
  output logic                is_full,
  output logic                is_empty
);

  lsnm_cmd_t ctl_cmd;
  lsnm_sts_t ctl_sts;

  assign cfg_ready = 1'b1;

  lsnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  lsnm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctl_cmd),
    .sts             (ctl_sts),
    .cfg_valid       (cfg_valid),
    .capacity_in_use (capacity_in_use),
    .command         (command),
    .node            (node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_node     (popped_node),
    .node_mark       (node_mark),
    .is_full         (is_full),
    .is_empty        (is_empty)
  );

endmodule

/* rtl/lsnm_checker.sv */
// ----------------------------------------------------------------------------
// lsnm_checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module lsnm_checker
  import lsnm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [NODE_W-1:0]   popped_node,
  input logic [MARK_W-1:0]   node_mark,
  input logic                is_full,
  input logic                is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_node)
      && $stable(node_mark) && $stable(is_full) && $stable(is_empty))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_full && is_empty))
    else $error("full and empty both set");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_EMPTY |-> is_empty && popped_node == '0 && node_mark == '0)
    else $error("pop on empty reported wrong fields");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_FULL |-> is_full && popped_node == '0)
    else $error("refused push without full flag");

  a_range_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_RANGE |-> node_mark == '0 && popped_node == '0 && !is_full)
    else $error("out-of-range push reported wrong fields");

endmodule

bind lifo_stack_with_node_marks_top lsnm_checker u_lsnm_checker (.*);

/* tb/tb_lifo_stack_with_node_marks_top.sv */
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_node_marks_top
// Self-checking bench for the node stack with white/gray/black node marks.
// A transaction-level predictor tracks the stack, the marks and the count. Each
// accepted command queues one predicted reply, and each returned reply is
// checked against the oldest one. Directed cases come first, then a random
// push/pop walk over several capacities with sender gaps, receiver stalls
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lifo_stack_with_node_marks_top;
  import lsnm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    status_t           status;
    logic [NODE_W-1:0] popped;
    mark_t             mark;
    logic              full;
    logic              empty;
  } stack_reply_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    capacity_in_use;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [NODE_W-1:0]   node;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   popped_node;
  logic [MARK_W-1:0]   node_mark;
  logic                is_full;
  logic                is_empty;

  // predictor state
  logic [NODE_W-1:0] slot_nodes [CAPACITY_DEFAULT];
  mark_t             mark_table [CAPACITY_DEFAULT];
  int                depth;
  logic [CFG_W-1:0]  cap_setting;

  stack_reply_t awaited_replies[$];
  int           mismatch_count;
  int           quiet_cycles;

  bit rx_hold_go;
  bit gaps_on;
  int burst_left;

  lifo_stack_with_node_marks_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .capacity_in_use (capacity_in_use),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .node            (node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_node     (popped_node),
    .node_mark       (node_mark),
    .is_full         (is_full),
    .is_empty        (is_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_capacity(logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > CAPACITY_DEFAULT) return CAPACITY_DEFAULT;
    return int'(setting);
  endfunction

  function automatic stack_reply_t next_stack_reply(logic [CMD_W-1:0] cmd,
                                                    logic [NODE_W-1:0] nd);
    stack_reply_t r;
    int lim;
    lim      = eff_capacity(cap_setting);
    r.status = STS_DONE;
    r.popped = '0;
    r.mark   = MARK_WHITE;
    case (cmd)
      CMD_PUSH: begin
        if (depth >= lim) begin
          r.status = STS_FULL;
          if (int'(nd) < lim) r.mark = mark_table[nd];
        end else if (int'(nd) >= lim) begin
          r.status = STS_RANGE;
        end else begin
          slot_nodes[depth] = nd;
          depth++;
          mark_table[nd] = MARK_GRAY;
          r.mark = MARK_GRAY;
        end
      end
      CMD_POP: begin
        if (depth == 0) begin
          r.status = STS_EMPTY;
        end else begin
          depth--;
          r.popped = slot_nodes[depth];
          mark_table[r.popped] = MARK_BLACK;
          r.mark = MARK_BLACK;
        end
      end
      CMD_CLEAR: begin
        depth = 0;
        foreach (mark_table[i]) mark_table[i] = MARK_WHITE;
      end
      default: ;
    endcase
    r.full  = (depth >= lim);
    r.empty = (depth == 0);
    return r;
  endfunction

  // predictor update and reply check
  always @(posedge clk) begin : reply_check
    stack_reply_t got;
    stack_reply_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) cap_setting = capacity_in_use;
      if (in_valid && in_ready) awaited_replies.push_back(next_stack_reply(command, node));
      if (out_valid && out_ready) begin
        got.status = status_t'(status);
        got.popped = popped_node;
        got.mark   = mark_t'(node_mark);
        got.full   = is_full;
        got.empty  = is_empty;
        if (awaited_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected transaction sts=%0d node=%0d mark=%0d full=%0b empty=%0b",
                     $realtime, got.status, got.popped, got.mark, got.full, got.empty);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status || got.popped !== want.popped ||
              got.mark !== want.mark || got.full !== want.full ||
              got.empty !== want.empty) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: mismatch exp sts=%0d node=%0d mark=%0d full=%0b empty=%0b",
                        " got sts=%0d node=%0d mark=%0d full=%0b empty=%0b"},
                       $realtime, want.status, want.popped, want.mark, want.full,
                       want.empty, got.status, got.popped, got.mark, got.full, got.empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int rx_mode;
    int rx_left;
    rx_mode   = 0;
    rx_left   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_go = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 2) != 0);
          default: out_ready <= (rx_left % 5 == 0);
        endcase
      end
    end
  end

  task automatic send_cmd(input cmd_t cmd, input logic [NODE_W-1:0] nd);
    int gap;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    command  <= cmd;
    node     <= nd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    capacity_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset capacity: empty pop, no-op, extreme nodes, drain past empty
  task automatic test_default_capacity();
    send_cmd(CMD_POP, 10'd0);
    send_cmd(CMD_NOP, 10'h3FF);
    send_cmd(CMD_PUSH, 10'h3FF);
    send_cmd(CMD_PUSH, 10'd0);
    send_cmd(CMD_POP, 10'h155);
    send_cmd(CMD_POP, 10'h2AA);
    send_cmd(CMD_POP, 10'd0);
  endtask

  // zero register acts as one slot; full check wins over range check
  task automatic test_single_slot();
    write_capacity(11'd0);
    send_cmd(CMD_PUSH, 10'd0);
    send_cmd(CMD_PUSH, 10'd0);
    send_cmd(CMD_PUSH, 10'd9);
    send_cmd(CMD_POP, 10'd0);
    send_cmd(CMD_PUSH, 10'd1);
    send_cmd(CMD_CLEAR, 10'd0);
  endtask

  // capacity lowered under the count, then raised past the maximum
  task automatic test_capacity_change();
    write_capacity(11'd16);
    send_cmd(CMD_PUSH, 10'd5);
    send_cmd(CMD_PUSH, 10'd6);
    send_cmd(CMD_PUSH, 10'd7);
    send_cmd(CMD_PUSH, 10'd8);
    write_capacity(11'd2);
    send_cmd(CMD_PUSH, 10'd1);
    send_cmd(CMD_POP, 10'd0);
    send_cmd(CMD_PUSH, 10'd8);
    write_capacity(11'h7FF);
    send_cmd(CMD_PUSH, 10'h3FF);
    send_cmd(CMD_POP, 10'd0);
    send_cmd(CMD_CLEAR, 10'd0);
    send_cmd(CMD_POP, 10'd0);
  endtask

  // receiver holds off while commands keep coming
  task automatic test_output_stall();
    write_capacity(11'd64);
    gaps_on    = 1'b0;
    rx_hold_go = 1'b1;
    for (int i = 0; i < 30; i++)
      send_cmd(($urandom_range(0, 3) != 0) ? CMD_PUSH : CMD_POP,
               NODE_W'($urandom_range(0, 70)));
  endtask

  // traversal-like walk: alternating push-heavy and pop-heavy stretches
  task automatic test_random_walk();
    logic [CFG_W-1:0] caps [9] = '{11'd3, 11'd1024, 11'd40, 11'd1, 11'h7FF,
                                   11'd12, 11'd1500, 11'd200, 11'd5};
    int lim;
    int pick;
    int push_pct;
    int run_left;
    cmd_t cmd;
    logic [NODE_W-1:0] nd;
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      lim      = eff_capacity(caps[p]);
      gaps_on  = (p % 3 != 0);
      run_left = 0;
      push_pct = 50;
      for (int i = 0; i < 200; i++) begin
        if (run_left == 0) begin
          push_pct = (push_pct > 50) ? 30 : 72;
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        pick = $urandom_range(0, 99);
        if (pick < 2) cmd = CMD_CLEAR;
        else if (pick < 5) cmd = CMD_NOP;
        else if (pick < 5 + push_pct) cmd = CMD_PUSH;
        else cmd = CMD_POP;
        if ($urandom_range(0, 9) == 0) nd = NODE_W'($urandom_range(0, 1023));
        else nd = NODE_W'($urandom_range(0, lim - 1));
        send_cmd(cmd, nd);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    capacity_in_use = CFG_RESET;
    in_valid        = 1'b0;
    command         = CMD_NOP;
    node            = '0;
    rx_hold_go      = 1'b0;
    gaps_on         = 1'b0;
    burst_left      = 0;
    depth           = 0;
    cap_setting     = CFG_RESET;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    foreach (mark_table[i]) mark_table[i] = MARK_WHITE;
    foreach (slot_nodes[i]) slot_nodes[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_capacity();
    test_single_slot();
    test_capacity_change();
    test_output_stall();
    test_random_walk();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_replies.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
